// ===== rtl/wrrl_pkg.sv =====
`timescale 1ns / 1ps

package wrrl_pkg;

    // Default sizes of the server and host tables
    localparam int DEF_SERVERS       = 8;
    localparam int DEF_HOSTS         = 256;
    localparam int DEF_SERVICE_TYPES = 4;

    // Request opcodes
    typedef enum logic [2:0] {
        CMD_REG_SRV  = 3'd0,
        CMD_DOWN     = 3'd1,
        CMD_UP       = 3'd2,
        CMD_FORGET   = 3'd3,
        CMD_REG_HOST = 3'd4,
        CMD_RENAME   = 3'd5,
        CMD_QUERY    = 3'd6
    } cmd_t;

    // Response codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FAILED  = 3'd1,
        ST_PINNED  = 3'd2,
        ST_ROAMING = 3'd3,
        ST_UNAVAIL = 3'd4,
        ST_BADCMD  = 3'd5
    } status_t;

    // One server slot as held in the server table
    typedef struct packed {
        logic              present;
        logic              sticky;
        logic signed [7:0] conf;
        logic signed [7:0] actual;
        logic [7:0]        tokens;
    } srv_ent_t;

    // Datapath micro-operations
    typedef enum logic [5:0] {
        OP_NONE     = 6'd0,
        OP_CLEAR    = 6'd1,
        OP_DECODE   = 6'd2,
        OP_REG_WR   = 6'd3,
        OP_SRV_RD   = 6'd4,
        OP_SRV_CHK  = 6'd5,
        OP_FGT_RD   = 6'd6,
        OP_FGT_CHK  = 6'd7,
        OP_UPD      = 6'd8,
        OP_EXC_INIT = 6'd9,
        OP_EXC_RD   = 6'd10,
        OP_EXC_CHK  = 6'd11,
        OP_PIN_RD   = 6'd12,
        OP_PIN_CHK  = 6'd13,
        OP_REN_RD1  = 6'd14,
        OP_REN_RD2  = 6'd15,
        OP_REN_CHK  = 6'd16,
        OP_REN_CLR  = 6'd17,
        OP_Q_RD     = 6'd18,
        OP_Q_CHK    = 6'd19,
        OP_QP_RD    = 6'd20,
        OP_QP_CHK   = 6'd21,
        OP_RR_RD    = 6'd22,
        OP_RR_CHK   = 6'd23,
        OP_WK_RD    = 6'd24,
        OP_WK_CHK   = 6'd25,
        OP_REF_INIT = 6'd26,
        OP_REF_RD   = 6'd27,
        OP_REF_CHK  = 6'd28,
        OP_REF_END  = 6'd29,
        OP_STK_RD   = 6'd30,
        OP_STK_CHK  = 6'd31,
        OP_FIN      = 6'd32
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   load;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic bad;
        logic w_neg;
        logic srv_present;
        logic conf_neg;
        logic walk_end;
        logic host_end;
        logic host_pinned;
        logic ren_ok;
        logic cur_valid;
        logic rr_excl;
        logic wk_done;
        logic wk_found;
        logic clr_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/weighted_round_robin_locator_core.sv =====
`timescale 1ns / 1ps

// Weighted round robin service locator.
// Requests enter on the s_axis channel, one transfer per request; each request
// gives exactly one response transfer on m_axis (status and server slot).
// Only one request is worked on at a time: s_axis_tready is high while the
// block is idle, including while a finished response still waits in the
// output register. A new request is taken in the idle state, entered from
// the finish step once the output register is free. Registering, downing or
// raising an exclusive server adds a walk of the server table of its service
// type. A roaming query walks the server table of its service type slot by
// slot and may end in a refill walk over all its slots. Forget walks the host
// table of its service type host by host. Both tables sit in RAMs with one
// shared address and one registered read port, and the walks are paced by
// that one registered read per step.
// After reset a clearing pass zeroes both tables, one entry per cycle, over
// max(SERVICE_TYPES*SERVERS, SERVICE_TYPES*HOSTS) entries (1024 by default);
// no request is taken until it ends.
// When m_axis_tready is low, the response holds in the output register and
// the next request completes up to its finish step, then waits.
module weighted_round_robin_locator_core
    import wrrl_pkg::*;
#(
    parameter int SERVERS       = DEF_SERVERS,
    parameter int HOSTS         = DEF_HOSTS,
    parameter int SERVICE_TYPES = DEF_SERVICE_TYPES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], service_type[4:3], server_slot[7:5], weight[15:8], sticky[16],
    // host_id[24:17], new_host_id[32:25], zero[39:33]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], server_out[5:3], zero[7:6]
    output logic [7:0]  m_axis_tdata
);

    ctl_t ctl;
    sts_t sts;

    wrrl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .ctl           (ctl)
    );

    wrrl_dp #(
        .SERVERS       (SERVERS),
        .HOSTS         (HOSTS),
        .SERVICE_TYPES (SERVICE_TYPES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/wrrl_ram.sv =====
`timescale 1ns / 1ps

module wrrl_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/wrrl_ctrl.sv =====
`timescale 1ns / 1ps

module wrrl_ctrl
    import wrrl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [32:0] {
        S_CLEAR    = 33'd1 << 0,
        S_IDLE     = 33'd1 << 1,
        S_DECODE   = 33'd1 << 2,
        S_REG_WR   = 33'd1 << 3,
        S_SRV_RD   = 33'd1 << 4,
        S_SRV_CHK  = 33'd1 << 5,
        S_FGT_RD   = 33'd1 << 6,
        S_FGT_CHK  = 33'd1 << 7,
        S_UPD      = 33'd1 << 8,
        S_EXC_INIT = 33'd1 << 9,
        S_EXC_RD   = 33'd1 << 10,
        S_EXC_CHK  = 33'd1 << 11,
        S_PIN_RD   = 33'd1 << 12,
        S_PIN_CHK  = 33'd1 << 13,
        S_REN_RD1  = 33'd1 << 14,
        S_REN_RD2  = 33'd1 << 15,
        S_REN_CHK  = 33'd1 << 16,
        S_REN_CLR  = 33'd1 << 17,
        S_Q_RD     = 33'd1 << 18,
        S_Q_CHK    = 33'd1 << 19,
        S_QP_RD    = 33'd1 << 20,
        S_QP_CHK   = 33'd1 << 21,
        S_RR_RD    = 33'd1 << 22,
        S_RR_CHK   = 33'd1 << 23,
        S_WK_RD    = 33'd1 << 24,
        S_WK_CHK   = 33'd1 << 25,
        S_REF_INIT = 33'd1 << 26,
        S_REF_RD   = 33'd1 << 27,
        S_REF_CHK  = 33'd1 << 28,
        S_REF_END  = 33'd1 << 29,
        S_STK_RD   = 33'd1 << 30,
        S_STK_CHK  = 33'd1 << 31,
        S_FIN      = 33'd1 << 32
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (sts.clr_done) state_next = S_IDLE;
            S_IDLE:     if (s_axis_tvalid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (sts.bad)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    unique case (sts.cmd)
                        CMD_REG_SRV:  state_next = S_REG_WR;
                        CMD_DOWN,
                        CMD_UP,
                        CMD_FORGET:   state_next = S_SRV_RD;
                        CMD_REG_HOST: state_next = S_PIN_RD;
                        CMD_RENAME:   state_next = S_REN_RD1;
                        CMD_QUERY:    state_next = S_Q_RD;
                        default:      state_next = S_FIN;
                    endcase
                end
            end
            S_REG_WR:   state_next = sts.w_neg ? S_EXC_INIT : S_FIN;
            S_SRV_RD:   state_next = S_SRV_CHK;
            S_SRV_CHK:
            begin
                if (!sts.srv_present)
                    state_next = S_FIN;
                else if (sts.cmd == CMD_FORGET)
                    state_next = S_FGT_RD;
                else
                    state_next = S_UPD;
            end
            S_FGT_RD:   state_next = S_FGT_CHK;
            S_FGT_CHK:  state_next = sts.host_end ? S_UPD : S_FGT_RD;
            S_UPD:      state_next = sts.conf_neg ? S_EXC_INIT : S_FIN;
            S_EXC_INIT: state_next = S_EXC_RD;
            S_EXC_RD:   state_next = S_EXC_CHK;
            S_EXC_CHK:  state_next = sts.walk_end ? S_FIN : S_EXC_RD;
            S_PIN_RD:   state_next = S_PIN_CHK;
            S_PIN_CHK:  state_next = S_FIN;
            S_REN_RD1:  state_next = S_REN_RD2;
            S_REN_RD2:  state_next = S_REN_CHK;
            S_REN_CHK:  state_next = sts.ren_ok ? S_REN_CLR : S_FIN;
            S_REN_CLR:  state_next = S_FIN;
            S_Q_RD:     state_next = S_Q_CHK;
            S_Q_CHK:
            begin
                if (sts.host_pinned)
                    state_next = S_QP_RD;
                else if (sts.cur_valid)
                    state_next = S_RR_RD;
                else
                    state_next = S_REF_INIT;
            end
            S_QP_RD:    state_next = S_QP_CHK;
            S_QP_CHK:   state_next = S_FIN;
            S_RR_RD:    state_next = S_RR_CHK;
            S_RR_CHK:   state_next = sts.rr_excl ? S_STK_RD : S_WK_RD;
            S_WK_RD:    state_next = S_WK_CHK;
            S_WK_CHK:
            begin
                if (!sts.wk_done)
                    state_next = S_WK_RD;
                else if (sts.wk_found)
                    state_next = S_STK_RD;
                else
                    state_next = S_REF_INIT;
            end
            S_REF_INIT: state_next = S_REF_RD;
            S_REF_RD:   state_next = S_REF_CHK;
            S_REF_CHK:  state_next = sts.walk_end ? S_REF_END : S_REF_RD;
            S_REF_END:  state_next = sts.cur_valid ? S_STK_RD : S_FIN;
            S_STK_RD:   state_next = S_STK_CHK;
            S_STK_CHK:  state_next = S_FIN;
            S_FIN:      if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
    end

    // Micro-operation and request load for the datapath
    always_comb
    begin
        ctl.load = s_axis_tready && s_axis_tvalid;
        unique case (state_reg)
            S_CLEAR:    ctl.op = OP_CLEAR;
            S_DECODE:   ctl.op = OP_DECODE;
            S_REG_WR:   ctl.op = OP_REG_WR;
            S_SRV_RD:   ctl.op = OP_SRV_RD;
            S_SRV_CHK:  ctl.op = OP_SRV_CHK;
            S_FGT_RD:   ctl.op = OP_FGT_RD;
            S_FGT_CHK:  ctl.op = OP_FGT_CHK;
            S_UPD:      ctl.op = OP_UPD;
            S_EXC_INIT: ctl.op = OP_EXC_INIT;
            S_EXC_RD:   ctl.op = OP_EXC_RD;
            S_EXC_CHK:  ctl.op = OP_EXC_CHK;
            S_PIN_RD:   ctl.op = OP_PIN_RD;
            S_PIN_CHK:  ctl.op = OP_PIN_CHK;
            S_REN_RD1:  ctl.op = OP_REN_RD1;
            S_REN_RD2:  ctl.op = OP_REN_RD2;
            S_REN_CHK:  ctl.op = OP_REN_CHK;
            S_REN_CLR:  ctl.op = OP_REN_CLR;
            S_Q_RD:     ctl.op = OP_Q_RD;
            S_Q_CHK:    ctl.op = OP_Q_CHK;
            S_QP_RD:    ctl.op = OP_QP_RD;
            S_QP_CHK:   ctl.op = OP_QP_CHK;
            S_RR_RD:    ctl.op = OP_RR_RD;
            S_RR_CHK:   ctl.op = OP_RR_CHK;
            S_WK_RD:    ctl.op = OP_WK_RD;
            S_WK_CHK:   ctl.op = OP_WK_CHK;
            S_REF_INIT: ctl.op = OP_REF_INIT;
            S_REF_RD:   ctl.op = OP_REF_RD;
            S_REF_CHK:  ctl.op = OP_REF_CHK;
            S_REF_END:  ctl.op = OP_REF_END;
            S_STK_RD:   ctl.op = OP_STK_RD;
            S_STK_CHK:  ctl.op = OP_STK_CHK;
            S_FIN:      ctl.op = OP_FIN;
            default:    ctl.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // The clearing pass must finish before any request is taken
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !sts.clr_done) |=> !s_axis_tready)
        else $error("request port opened during clearing pass");

endmodule

// ===== rtl/wrrl_dp.sv =====
`timescale 1ns / 1ps

module wrrl_dp
    import wrrl_pkg::*;
#(
    parameter int SERVERS       = DEF_SERVERS,
    parameter int HOSTS         = DEF_HOSTS,
    parameter int SERVICE_TYPES = DEF_SERVICE_TYPES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output sts_t        sts,
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata
);

    localparam int SW         = $clog2(SERVERS);
    localparam int HW         = $clog2(HOSTS);
    localparam int TIW        = (SERVICE_TYPES > 1) ? $clog2(SERVICE_TYPES) : 1;
    localparam int KW         = (SW > HW) ? SW : HW;
    localparam int SRV_DEPTH  = SERVICE_TYPES * SERVERS;
    localparam int HOST_DEPTH = SERVICE_TYPES * HOSTS;
    localparam int SA         = $clog2(SRV_DEPTH);
    localparam int HA         = $clog2(HOST_DEPTH);
    localparam int CLR_DEPTH  = (SRV_DEPTH > HOST_DEPTH) ? SRV_DEPTH : HOST_DEPTH;
    localparam int CW         = $clog2(CLR_DEPTH);
    localparam int SRV_W      = $bits(srv_ent_t);
    localparam int HE_W       = SW + 2;

    // Latched request
    logic [2:0]        cmd_reg;
    logic [1:0]        t_reg;
    logic [2:0]        s_reg;
    logic signed [7:0] w_reg;
    logic              sticky_reg;
    logic [7:0]        h_reg;
    logic [7:0]        nh_reg;

    // Working registers
    srv_ent_t          ent_reg;
    logic [HE_W-1:0]   hj_reg;
    logic [SW-1:0]     p_reg;
    logic [SW-1:0]     nx_reg;
    logic [SW-1:0]     sel_reg;
    status_t           status_reg;
    logic signed [7:0] minw_reg;
    logic [KW-1:0]     k_reg;
    logic [CW-1:0]     clr_reg;

    // Round robin pointer per service type
    logic              cur_valid_reg [SERVICE_TYPES];
    logic [SW-1:0]     cur_slot_reg  [SERVICE_TYPES];

    // Output register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [2:0]        out_srv_reg;

    // RAM ports
    logic              srv_we;
    logic [SA-1:0]     srv_addr;
    logic [SRV_W-1:0]  srv_rdata;
    srv_ent_t          srv_wd;
    srv_ent_t          rd;
    logic              host_we;
    logic [HA-1:0]     host_addr;
    logic [HE_W-1:0]   host_wd;
    logic [HE_W-1:0]   hr;

    logic [SW-1:0]     srv_slot;
    logic [HW-1:0]     host_idx;
    logic [TIW-1:0]    t_idx;
    logic [SW-1:0]     s_idx;
    logic [HW-1:0]     h_idx;
    logic [HW-1:0]     nh_idx;
    logic [SW-1:0]     cur_last;
    logic [SW-1:0]     nxn;
    logic              need_slot;
    logic              need_host;
    logic              clearing;

    assign t_idx    = TIW'(t_reg);
    assign s_idx    = SW'(s_reg);
    assign h_idx    = HW'(h_reg);
    assign nh_idx   = HW'(nh_reg);
    assign cur_last = cur_slot_reg[t_idx];
    assign nxn      = (nx_reg == SW'(SERVERS - 1)) ? '0 : nx_reg + 1'b1;
    assign rd       = srv_ent_t'(srv_rdata);
    assign clearing = (ctl.op == OP_CLEAR);

    // Range checks of the request
    assign need_slot = (cmd_reg <= CMD_REG_HOST);
    assign need_host = (cmd_reg == CMD_REG_HOST) || (cmd_reg == CMD_RENAME)
                       || (cmd_reg == CMD_QUERY);

    // Status toward the controller
    always_comb
    begin
        sts.cmd         = cmd_t'(cmd_reg);
        sts.bad         = (cmd_reg > CMD_QUERY) || (32'(t_reg) >= SERVICE_TYPES)
                          || (need_slot && 32'(s_reg) >= SERVERS)
                          || (need_host && 32'(h_reg) >= HOSTS)
                          || (cmd_reg == CMD_RENAME && 32'(nh_reg) >= HOSTS);
        sts.w_neg       = (w_reg < 8'sd0);
        sts.srv_present = rd.present;
        sts.conf_neg    = (ent_reg.conf < 8'sd0);
        sts.walk_end    = (k_reg[SW-1:0] == SW'(SERVERS - 1));
        sts.host_end    = (k_reg[HW-1:0] == HW'(HOSTS - 1));
        sts.host_pinned = hr[SW+1] && hr[SW];
        sts.ren_ok      = hj_reg[SW+1] && !hr[SW+1];
        sts.cur_valid   = cur_valid_reg[t_idx];
        sts.rr_excl     = (rd.actual < 8'sd0);
        sts.wk_done     = (rd.present && (rd.tokens != 8'd0 || nx_reg == cur_last))
                          || (k_reg[SW-1:0] == SW'(SERVERS - 1));
        sts.wk_found    = !(nx_reg == cur_last && rd.tokens == 8'd0);
        sts.clr_done    = (clr_reg == CW'(CLR_DEPTH - 1));
        sts.out_free    = !out_valid_reg || m_axis_tready;
    end

    // Table addresses and write data
    always_comb
    begin
        srv_ent_t ent_w;
        ent_w    = rd;
        srv_slot = s_idx;
        host_idx = h_idx;
        srv_we   = 1'b0;
        srv_wd   = rd;
        host_we  = 1'b0;
        host_wd  = hr;
        unique case (ctl.op)
            OP_CLEAR:
            begin
                srv_we  = (32'(clr_reg) < SRV_DEPTH);
                srv_wd  = '0;
                host_we = (32'(clr_reg) < HOST_DEPTH);
                host_wd = '0;
            end
            OP_REG_WR:
            begin
                srv_we = 1'b1;
                srv_wd = '{present: 1'b1, sticky: sticky_reg, conf: w_reg,
                           actual: w_reg, tokens: 8'd0};
            end
            OP_UPD:
            begin
                ent_w = ent_reg;
                if (cmd_reg == CMD_UP)
                begin
                    ent_w.actual = ent_reg.conf;
                end
                else
                begin
                    ent_w.actual = 8'sd0;
                    ent_w.tokens = 8'd0;
                end
                srv_we = 1'b1;
                srv_wd = ent_w;
            end
            OP_FGT_RD:
            begin
                host_idx = k_reg[HW-1:0];
            end
            OP_FGT_CHK:
            begin
                host_idx   = k_reg[HW-1:0];
                host_we    = hr[SW] && (hr[SW-1:0] == s_idx);
                host_wd[SW] = 1'b0;
            end
            OP_EXC_RD, OP_EXC_CHK, OP_REF_RD:
            begin
                srv_slot = k_reg[SW-1:0];
            end
            OP_PIN_CHK:
            begin
                srv_we  = !rd.present;
                srv_wd  = '{present: 1'b1, sticky: 1'b1, conf: 8'sd1,
                            actual: 8'sd1, tokens: 8'd0};
                host_we = 1'b1;
                host_wd = {1'b1, 1'b1, s_idx};
            end
            OP_REN_RD2:
            begin
                host_idx = nh_idx;
            end
            OP_REN_CHK:
            begin
                host_idx = nh_idx;
                host_we  = sts.ren_ok;
                host_wd  = hj_reg;
            end
            OP_REN_CLR:
            begin
                host_we = 1'b1;
                host_wd = '0;
            end
            OP_QP_RD:
            begin
                srv_slot = p_reg;
            end
            OP_RR_RD:
            begin
                srv_slot = cur_last;
            end
            OP_RR_CHK:
            begin
                // take the token of the server used last
                srv_slot     = cur_last;
                ent_w.tokens = rd.tokens - 8'd1;
                srv_we       = !sts.rr_excl && (rd.actual > 8'sd1) && (rd.tokens != 8'd0);
                srv_wd       = ent_w;
            end
            OP_WK_RD:
            begin
                srv_slot = nxn;
            end
            OP_WK_CHK:
            begin
                srv_slot = nx_reg;
            end
            OP_REF_CHK:
            begin
                // new round: weight minus one tokens for each sharing server
                srv_slot     = k_reg[SW-1:0];
                ent_w.tokens = $unsigned(rd.actual - 8'sd1);
                srv_we       = rd.present && (rd.actual > 8'sd1);
                srv_wd       = ent_w;
            end
            OP_STK_RD:
            begin
                srv_slot = sel_reg;
            end
            OP_STK_CHK:
            begin
                host_we = rd.sticky;
                host_wd = {1'b1, 1'b1, sel_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign srv_addr  = clearing ? SA'(clr_reg)
                                : SA'(32'(t_reg) * SERVERS + 32'(srv_slot));
    assign host_addr = clearing ? HA'(clr_reg)
                                : HA'(32'(t_reg) * HOSTS + 32'(host_idx));

    wrrl_ram #(
        .WIDTH (SRV_W),
        .DEPTH (SRV_DEPTH)
    ) u_srv_ram (
        .clk   (clk),
        .we    (srv_we),
        .waddr (srv_addr),
        .wdata (srv_wd),
        .raddr (srv_addr),
        .rdata (srv_rdata)
    );

    wrrl_ram #(
        .WIDTH (HE_W),
        .DEPTH (HOST_DEPTH)
    ) u_host_ram (
        .clk   (clk),
        .we    (host_we),
        .waddr (host_addr),
        .wdata (host_wd),
        .raddr (host_addr),
        .rdata (hr)
    );

    // Request latch and working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= s_axis_tdata[2:0];
            t_reg      <= s_axis_tdata[4:3];
            s_reg      <= s_axis_tdata[7:5];
            w_reg      <= s_axis_tdata[15:8];
            sticky_reg <= s_axis_tdata[16];
            h_reg      <= s_axis_tdata[24:17];
            nh_reg     <= s_axis_tdata[32:25];
        end
        unique case (ctl.op)
            OP_DECODE:
            begin
                status_reg <= sts.bad ? ST_BADCMD : ST_OK;
                sel_reg    <= '0;
            end
            OP_SRV_CHK:
            begin
                ent_reg <= rd;
                k_reg   <= '0;
            end
            OP_FGT_CHK, OP_REF_CHK:
            begin
                k_reg <= k_reg + 1'b1;
            end
            OP_EXC_INIT, OP_REF_INIT:
            begin
                minw_reg <= 8'sd0;
                k_reg    <= '0;
            end
            OP_EXC_CHK:
            begin
                if (rd.present && rd.actual < minw_reg)
                begin
                    minw_reg <= rd.actual;
                end
                k_reg <= k_reg + 1'b1;
            end
            OP_REN_RD2:
            begin
                hj_reg <= hr;
            end
            OP_REN_CHK:
            begin
                if (!sts.ren_ok)
                begin
                    status_reg <= ST_FAILED;
                end
            end
            OP_Q_CHK:
            begin
                p_reg <= hr[SW-1:0];
            end
            OP_QP_CHK:
            begin
                if (rd.actual > 8'sd0)
                begin
                    status_reg <= ST_PINNED;
                    sel_reg    <= p_reg;
                end
                else
                begin
                    status_reg <= ST_UNAVAIL;
                end
            end
            OP_RR_CHK:
            begin
                sel_reg <= cur_last;
                nx_reg  <= cur_last;
                k_reg   <= '0;
            end
            OP_WK_RD:
            begin
                nx_reg <= nxn;
            end
            OP_WK_CHK:
            begin
                if (sts.wk_done)
                begin
                    if (sts.wk_found)
                    begin
                        sel_reg <= nx_reg;
                    end
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            OP_REF_END:
            begin
                if (cur_valid_reg[t_idx])
                begin
                    sel_reg <= cur_last;
                end
                else
                begin
                    status_reg <= ST_UNAVAIL;
                    sel_reg    <= '0;
                end
            end
            OP_STK_CHK:
            begin
                status_reg <= ST_ROAMING;
            end
            default:
            begin
            end
        endcase
    end

    // Pointer table, clearing counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SERVICE_TYPES; i++)
            begin
                cur_valid_reg[i] <= 1'b0;
                cur_slot_reg[i]  <= '0;
            end
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_srv_reg    <= '0;
        end
        else
        begin
            if (clearing && !sts.clr_done)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            unique case (ctl.op)
                OP_EXC_INIT, OP_REF_INIT:
                begin
                    cur_valid_reg[t_idx] <= 1'b0;
                    cur_slot_reg[t_idx]  <= '0;
                end
                OP_EXC_CHK:
                begin
                    if (rd.present && rd.actual < minw_reg)
                    begin
                        cur_valid_reg[t_idx] <= 1'b1;
                        cur_slot_reg[t_idx]  <= k_reg[SW-1:0];
                    end
                end
                OP_WK_CHK:
                begin
                    if (sts.wk_done)
                    begin
                        cur_slot_reg[t_idx] <= nx_reg;
                    end
                end
                OP_REF_CHK:
                begin
                    if (rd.present && rd.actual > 8'sd1 && !cur_valid_reg[t_idx])
                    begin
                        cur_valid_reg[t_idx] <= 1'b1;
                        cur_slot_reg[t_idx]  <= k_reg[SW-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            // result register: load at finish, drop after transfer
            if (ctl.op == OP_FIN && sts.out_free)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_reg;
                out_srv_reg    <= 3'(sel_reg);
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_srv_reg, out_status_reg};

    // A server is reported only with a pinned or roaming hit
    a_srv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_PINNED && out_status_reg != ST_ROAMING)
        |-> (out_srv_reg == 3'd0))
        else $error("server reported without a hit");

    // Result register only loads at the finish step
    a_load_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.op == OP_FIN))
        else $error("result loaded outside finish step");

endmodule
